FILE: rtl/bq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the multichannel biquad.
// No dependencies; imported by every module of the block.
package bq_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int SAMPLE_W         = 24;
  localparam int CHAN_W           = 3;
  localparam int COEF_W           = 32;
  localparam int CNT_W            = 4;
  localparam int DELAY_W          = 48;
  localparam int PROD_W           = COEF_W + SAMPLE_W;
  localparam int ACC_W            = 64;
  localparam int APB_AW           = 5;
  localparam int APB_DW           = 32;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_B0  = 3'd0;
  localparam logic [2:0] REG_B1  = 3'd1;
  localparam logic [2:0] REG_B2  = 3'd2;
  localparam logic [2:0] REG_A1  = 3'd3;
  localparam logic [2:0] REG_A2  = 3'd4;
  localparam logic [2:0] REG_CNT = 3'd5;

  localparam logic signed [COEF_W-1:0] B0_RESET  = 32'sh4000_0000;
  localparam logic [CNT_W-1:0]         CNT_RESET = 4'd2;

  localparam logic signed [ACC_W-1:0] RND_Y   = 64'sd536870912;  // 2^29
  localparam logic signed [ACC_W-1:0] RND_D   = 64'sd4096;       // 2^12
  localparam logic signed [ACC_W-1:0] Q23_MAX = 64'sd8388607;
  localparam logic signed [ACC_W-1:0] Q23_MIN = -64'sd8388608;
  localparam logic signed [ACC_W-1:0] D48_MAX = 64'sd140737488355327;
  localparam logic signed [ACC_W-1:0] D48_MIN = -64'sd140737488355328;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } bq_coef_t;

  typedef struct packed {
    logic signed [DELAY_W-1:0] d1;
    logic signed [DELAY_W-1:0] d2;
  } bq_delay_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MB0,
    ST_Y,
    ST_D1A,
    ST_D1B,
    ST_D2A,
    ST_D2B,
    ST_OUT
  } bq_state_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_q23(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > Q23_MAX) r = Q23_MAX[SAMPLE_W-1:0];
    else if (v < Q23_MIN) r = Q23_MIN[SAMPLE_W-1:0];
    else r = v[SAMPLE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [DELAY_W-1:0] sat_d48(input logic signed [ACC_W-1:0] v);
    logic signed [DELAY_W-1:0] r;
    if (v > D48_MAX) r = D48_MAX[DELAY_W-1:0];
    else if (v < D48_MIN) r = D48_MIN[DELAY_W-1:0];
    else r = v[DELAY_W-1:0];
    return r;
  endfunction

endpackage

FILE: rtl/bq_dmem.sv
`timescale 1ns / 1ps
// Per-channel delay store: one synchronous memory word holds both delays.
// Uses bq_pkg; entries never written since reset or a clear read as zero.
module bq_dmem #(
  parameter int MAX_CHANNELS = bq_pkg::MAX_CHANNELS_DEF,
  parameter int AW           = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output bq_pkg::bq_delay_t rd_data,
  input  logic              we,
  input  logic [AW-1:0]     wr_addr,
  input  bq_pkg::bq_delay_t wr_data
);
  import bq_pkg::*;

  bq_delay_t                mem_q [MAX_CHANNELS];
  bq_delay_t                rd_q_r;
  logic                     rd_vld_r;
  logic [MAX_CHANNELS-1:0]  vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

FILE: rtl/bq_core.sv
`timescale 1ns / 1ps
// Sequencer and datapath: one shared 32x24 multiplier and a 64-bit accumulator
// run the section per word, read-modify-write on the delay store. Uses bq_pkg.
module bq_core #(
  parameter int MAX_CHANNELS = bq_pkg::MAX_CHANNELS_DEF,
  parameter int AW           = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bq_pkg::bq_coef_t                    coef,
  input  logic [bq_pkg::CNT_W-1:0]            chan_count,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bq_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic [bq_pkg::CHAN_W-1:0]           in_channel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bq_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic [bq_pkg::CHAN_W-1:0]           out_channel,
  output logic                                mem_rd_en,
  output logic [AW-1:0]                       mem_rd_addr,
  input  bq_pkg::bq_delay_t                   mem_rd_data,
  output logic                                mem_we,
  output logic [AW-1:0]                       mem_wr_addr,
  output bq_pkg::bq_delay_t                   mem_wr_data
);
  import bq_pkg::*;

  localparam logic [5:0] MAX_CH = 6'(MAX_CHANNELS);

  bq_state_t                  state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic [CHAN_W-1:0]          ch_r, ch_nxt;
  logic signed [SAMPLE_W-1:0] y_r, y_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [DELAY_W-1:0]  d1n_r, d1n_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic [CHAN_W-1:0]          out_channel_r, out_channel_nxt;

  logic signed [COEF_W-1:0]   mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [ACC_W-1:0]    prod_ext, d1_ext, d2_ext;
  logic                       in_act;

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  // delays are Q8.40, products carry 53 fraction bits: align by 2^13
  assign d1_ext   = {{(ACC_W-DELAY_W-13){mem_rd_data.d1[DELAY_W-1]}}, mem_rd_data.d1, 13'd0};
  assign d2_ext   = {{(ACC_W-DELAY_W-13){mem_rd_data.d2[DELAY_W-1]}}, mem_rd_data.d2, 13'd0};

  assign in_act = (CNT_W'(in_channel) < chan_count) && (6'(in_channel) < MAX_CH);

  assign in_stall       = (state_r != ST_IDLE);
  assign mem_rd_addr    = AW'(in_channel);
  assign mem_wr_addr    = AW'(ch_r);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_channel    = out_channel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r           <= x_nxt;
    ch_r          <= ch_nxt;
    y_r           <= y_nxt;
    prod_r        <= prod_nxt;
    acc_r         <= acc_nxt;
    d1n_r         <= d1n_nxt;
    out_sample_r  <= out_sample_nxt;
    out_channel_r <= out_channel_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    x_nxt           = x_r;
    ch_nxt          = ch_r;
    y_nxt           = y_r;
    prod_nxt        = prod_r;
    acc_nxt         = acc_r;
    d1n_nxt         = d1n_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_sample_nxt  = out_sample_r;
    out_channel_nxt = out_channel_r;
    mul_a           = coef.b0;
    mul_b           = x_r;
    mem_rd_en       = 1'b0;
    mem_we          = 1'b0;
    mem_wr_data     = '{d1: d1n_r, d2: '0};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mem_rd_en = 1'b1;
          x_nxt     = in_sample_in;
          ch_nxt    = in_channel;
          y_nxt     = in_sample_in;   // inactive channel passes through
          state_nxt = in_act ? ST_MB0 : ST_OUT;
        end
      end
      ST_MB0: begin
        mul_a     = coef.b0;
        prod_nxt  = mul_p;
        state_nxt = ST_Y;
      end
      ST_Y: begin
        y_nxt     = sat_q23((prod_ext + d1_ext + RND_Y) >>> 30);
        mul_a     = coef.b1;
        prod_nxt  = mul_p;
        state_nxt = ST_D1A;
      end
      ST_D1A: begin
        acc_nxt   = prod_ext + d2_ext;
        mul_a     = coef.a1;
        mul_b     = y_r;
        prod_nxt  = mul_p;
        state_nxt = ST_D1B;
      end
      ST_D1B: begin
        d1n_nxt   = sat_d48((acc_r - prod_ext + RND_D) >>> 13);
        mul_a     = coef.b2;
        prod_nxt  = mul_p;
        state_nxt = ST_D2A;
      end
      ST_D2A: begin
        acc_nxt   = prod_ext;
        mul_a     = coef.a2;
        mul_b     = y_r;
        prod_nxt  = mul_p;
        state_nxt = ST_D2B;
      end
      ST_D2B: begin
        mem_we      = 1'b1;
        mem_wr_data = '{d1: d1n_r, d2: sat_d48((acc_r - prod_ext + RND_D) >>> 13)};
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // wait here while the previous word is still held at the output
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt   = 1'b1;
          out_sample_nxt  = y_r;
          out_channel_nxt = ch_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/biquad_df2t_multichannel.sv
`timescale 1ns / 1ps
// Transposed direct form II biquad shared by interleaved channels: register block,
// delay store and sequencer. Uses bq_pkg, bq_dmem and bq_core.
//
// From acceptance to the next acceptance, with the output free, an active-channel
// word takes one read of the delay memory, five products through the single
// 32x24 multiplier with a 64-bit accumulate after each, one write-back of both
// delays and the load of the output register. A word for an inactive channel
// (channel >= min(count, MAX_CHANNELS)) passes straight to the output register
// and leaves the delays untouched. One word is in flight at a time; the
// output register holds a finished word while the next one is taken. Delays
// reset to zero through per-entry valid bits, cleared at reset and whenever a
// different channel count is written, so there is no clearing pass.
module biquad_df2t_multichannel #(
  parameter int MAX_CHANNELS = bq_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bq_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic [bq_pkg::CHAN_W-1:0]           in_channel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bq_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic [bq_pkg::CHAN_W-1:0]           out_channel,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bq_pkg::APB_AW-1:0]           paddr,
  input  logic [bq_pkg::APB_DW-1:0]           pwdata,
  output logic [bq_pkg::APB_DW-1:0]           prdata,
  output logic                                pready
);
  import bq_pkg::*;

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  bq_coef_t          coef_r;
  logic [CNT_W-1:0]  count_r;
  logic              cfg_wr;
  logic [2:0]        reg_idx;
  logic              mem_clr;

  logic              mem_rd_en, mem_we;
  logic [AW-1:0]     mem_rd_addr, mem_wr_addr;
  bq_delay_t         mem_rd_data, mem_wr_data;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign mem_clr = cfg_wr && (reg_idx == REG_CNT) && (pwdata[CNT_W-1:0] != count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r  <= '{b0: B0_RESET, b1: '0, b2: '0, a1: '0, a2: '0};
      count_r <= CNT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_B0:  coef_r.b0 <= pwdata;
        REG_B1:  coef_r.b1 <= pwdata;
        REG_B2:  coef_r.b2 <= pwdata;
        REG_A1:  coef_r.a1 <= pwdata;
        REG_A2:  coef_r.a2 <= pwdata;
        REG_CNT: count_r   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_B0:  prdata = coef_r.b0;
      REG_B1:  prdata = coef_r.b1;
      REG_B2:  prdata = coef_r.b2;
      REG_A1:  prdata = coef_r.a1;
      REG_A2:  prdata = coef_r.a2;
      REG_CNT: prdata = APB_DW'(count_r);
      default: prdata = '0;
    endcase
  end

  bq_dmem #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW)
  ) u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (mem_clr),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  bq_core #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .coef           (coef_r),
    .chan_count     (count_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .in_channel     (in_channel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_channel    (out_channel),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data),
    .mem_we         (mem_we),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data)
  );

`ifndef SYNTHESIS
  logic chk_act;
  assign chk_act = (CNT_W'(in_channel) < count_r) && (6'(in_channel) < 6'(MAX_CHANNELS));

  // an active word writes its delays back in ST_D2B after acceptance
  a_wb_timing: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && chk_act |-> ##6 mem_we)
    else $error("delay write-back missing after active word");

  // write-back never coincides with taking a new word
  a_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> in_stall)
    else $error("delay write-back while accepting");

  // one word in flight: no acceptance in the cycle after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");
`endif

endmodule
